FILE: src/rse_pkg.sv
// rse_pkg: shared types and constants for the register and stack executor
// no dependencies
package rse_pkg;

    localparam int unsigned NUM_REGS_C = 16;

    typedef enum logic [3:0] {
        OP_NOP    = 4'd0,
        OP_MOVREG = 4'd1,
        OP_MOVIMM = 4'd2,
        OP_ADDREG = 4'd3,
        OP_ADDIMM = 4'd4,
        OP_SUBREG = 4'd5,
        OP_SUBIMM = 4'd6,
        OP_PUSH   = 4'd7,
        OP_POP    = 4'd8,
        OP_STR    = 4'd9,
        OP_LDR    = 4'd10
    } t_opcode;

    typedef struct packed {
        logic [3:0]         opcode;
        logic [3:0]         dst_reg;
        logic [3:0]         src_reg;
        logic [3:0]         src2_reg;
        logic [31:0]        immediate;
        logic signed [15:0] byte_offset;
        logic [15:0]        register_list;
    } t_in_word;

    typedef struct packed {
        logic        reg_written;
        logic [3:0]  written_index;
        logic [31:0] written_value;
        logic [31:0] stack_pointer;
        logic        mem_written;
        logic [31:0] mem_address;
        logic [31:0] mem_data;
        logic        address_fault;
    } t_out_word;

    // controller to datapath commands
    typedef enum logic [2:0] {
        CMD_IDLE  = 3'd0,
        CMD_LOAD  = 3'd1,   // latch instruction, clear result
        CMD_ALU   = 3'd2,   // mov/add/sub into dst
        CMD_STR   = 3'd3,
        CMD_LDR   = 3'd4,
        CMD_PUSH  = 3'd5,   // one push step for register idx
        CMD_POP   = 3'd6,   // one pop step for register idx
        CMD_LDONE = 3'd7    // finish a load: write the read word
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op     op;
        logic [3:0]  idx;
    } t_cmd;

    typedef struct packed {
        t_opcode     opcode;
        logic [15:0] register_list;
    } t_status;

endpackage

FILE: src/rse_ctrl.sv
// rse_ctrl: sequencer for instruction execution and push/pop walks
// depends on rse_pkg
module rse_ctrl
    import rse_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_WALK, S_LWAIT, S_DONE
    } t_state;

    t_state     r_state;
    logic [3:0] r_step;
    logic       r_pop_wait;
    logic [3:0] w_idx;

    // push walks high to low, pop low to high
    assign w_idx = (i_status.opcode == OP_PUSH) ? (4'd15 - r_step) : r_step;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_DONE);

    always_comb begin
        o_cmd.op  = CMD_IDLE;
        o_cmd.idx = w_idx;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) o_cmd.op = CMD_LOAD;
            end
            S_DECODE: begin
                case (i_status.opcode)
                    OP_MOVREG, OP_MOVIMM, OP_ADDREG, OP_ADDIMM,
                    OP_SUBREG, OP_SUBIMM: o_cmd.op = CMD_ALU;
                    OP_STR: o_cmd.op = CMD_STR;
                    OP_LDR: o_cmd.op = CMD_LDR;
                    default: o_cmd.op = CMD_IDLE;
                endcase
            end
            S_WALK: begin
                if (i_status.register_list[w_idx]) begin
                    o_cmd.op = (i_status.opcode == OP_PUSH) ? CMD_PUSH : CMD_POP;
                end
            end
            S_LWAIT: o_cmd.op = CMD_LDONE;
            S_DONE: o_cmd.op = CMD_IDLE;
            default: o_cmd.op = CMD_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_step     <= '0;
            r_pop_wait <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) r_state <= S_DECODE;
                end
                S_DECODE: begin
                    r_step <= '0;
                    if (i_status.opcode == OP_PUSH || i_status.opcode == OP_POP)
                        r_state <= S_WALK;
                    else if (i_status.opcode == OP_LDR)
                        r_state <= S_LWAIT;
                    else
                        r_state <= S_DONE;
                end
                S_WALK: begin
                    if (o_cmd.op == CMD_POP) begin
                        r_state <= S_LWAIT;
                        r_pop_wait <= 1'b1;
                    end else if (r_step == 4'd15) begin
                        r_state <= S_DONE;
                    end else begin
                        r_step <= r_step + 4'd1;
                    end
                end
                S_LWAIT: begin
                    if (r_pop_wait) begin
                        r_pop_wait <= 1'b0;
                        if (r_step == 4'd15) r_state <= S_DONE;
                        else begin
                            r_step  <= r_step + 4'd1;
                            r_state <= S_WALK;
                        end
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (i_out_ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: src/rse_datapath.sv
// rse_datapath: register file, stack memory and result register
// depends on rse_pkg
module rse_datapath
    import rse_pkg::*;
#(
    parameter int unsigned STACK_WORDS = 1024,
    parameter int unsigned SP_INDEX    = 13
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_word  i_in_word,
    input  t_cmd      i_cmd,
    output t_status   o_status,
    output t_out_word o_out_word
);

    localparam int unsigned AW = $clog2(STACK_WORDS);
    localparam logic [3:0] SP = SP_INDEX[3:0];
    localparam logic [32:0] TOP = 33'(4 * STACK_WORDS);

    logic [31:0] r_regs [NUM_REGS_C];
    logic [31:0] r_mem  [STACK_WORDS];
    t_in_word    r_ins;
    t_out_word   r_res;
    logic [31:0] r_rdata;
    logic [31:0] r_laddr;
    logic        r_lok;
    logic [3:0]  r_ldst;

    logic [31:0] w_off, w_addr, w_sp, w_sp_dec, w_alu, w_a, w_b;
    logic        w_ok_addr, w_ok_dec, w_ok_sp;

    function automatic logic f_ok(input logic [31:0] a);
        return (a[1:0] == 2'b00) && ({1'b0, a} < TOP);
    endfunction

    assign w_off     = {{16{r_ins.byte_offset[15]}}, r_ins.byte_offset};
    assign w_addr    = r_regs[r_ins.src_reg] + w_off;
    assign w_sp      = r_regs[SP];
    assign w_sp_dec  = w_sp - 32'd4;
    assign w_ok_addr = f_ok(w_addr);
    assign w_ok_dec  = f_ok(w_sp_dec);
    assign w_ok_sp   = f_ok(w_sp);
    assign w_a       = r_regs[r_ins.src_reg];
    assign w_b       = (r_ins.opcode == OP_ADDREG || r_ins.opcode == OP_SUBREG) ?
                       r_regs[r_ins.src2_reg] : r_ins.immediate;

    always_comb begin
        case (r_ins.opcode)
            OP_MOVREG:            w_alu = w_a;
            OP_MOVIMM:            w_alu = r_ins.immediate;
            OP_ADDREG, OP_ADDIMM: w_alu = w_a + w_b;
            default:              w_alu = w_a - w_b;
        endcase
    end

    assign o_status.opcode        = t_opcode'(r_ins.opcode);
    assign o_status.register_list = r_ins.register_list;

    always_comb begin
        o_out_word = r_res;
        o_out_word.stack_pointer = r_regs[SP];
    end

    // stack memory, one write port and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == CMD_STR && w_ok_addr)
            r_mem[w_addr[AW+1:2]] <= r_regs[r_ins.dst_reg];
        else if (i_cmd.op == CMD_PUSH && w_ok_dec)
            r_mem[w_sp_dec[AW+1:2]] <= (i_cmd.idx == SP) ? w_sp_dec : r_regs[i_cmd.idx];
        r_rdata <= r_mem[(i_cmd.op == CMD_POP) ? w_sp[AW+1:2] : w_addr[AW+1:2]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_REGS_C; k++) r_regs[k] <= '0;
            r_regs[SP] <= TOP[31:0];
        end else begin
            case (i_cmd.op)
                CMD_LOAD: begin
                    r_ins <= i_in_word;
                    r_res <= '0;
                end
                CMD_ALU: begin
                    r_regs[r_ins.dst_reg] <= w_alu;
                    r_res.reg_written   <= 1'b1;
                    r_res.written_index <= r_ins.dst_reg;
                    r_res.written_value <= w_alu;
                end
                CMD_STR: begin
                    if (w_ok_addr) begin
                        r_res.mem_written <= 1'b1;
                        r_res.mem_address <= w_addr;
                        r_res.mem_data    <= r_regs[r_ins.dst_reg];
                    end else r_res.address_fault <= 1'b1;
                end
                CMD_LDR: begin
                    r_laddr <= w_addr;
                    r_lok   <= w_ok_addr;
                    r_ldst  <= r_ins.dst_reg;
                    if (!w_ok_addr) r_res.address_fault <= 1'b1;
                end
                CMD_PUSH: begin
                    r_regs[SP] <= w_sp_dec;
                    if (w_ok_dec) begin
                        r_res.mem_written <= 1'b1;
                        r_res.mem_address <= w_sp_dec;
                        r_res.mem_data    <= (i_cmd.idx == SP) ? w_sp_dec
                                                               : r_regs[i_cmd.idx];
                    end else r_res.address_fault <= 1'b1;
                end
                CMD_POP: begin
                    // sp advances after the load lands
                    r_laddr <= w_sp;
                    r_lok   <= w_ok_sp;
                    r_ldst  <= i_cmd.idx;
                    if (!w_ok_sp) r_res.address_fault <= 1'b1;
                end
                CMD_LDONE: begin
                    if (r_lok) begin
                        // a pop into sp is written below together with its advance
                        if (r_ins.opcode != OP_POP || r_ldst != SP)
                            r_regs[r_ldst] <= r_rdata;
                        r_res.reg_written   <= 1'b1;
                        r_res.written_index <= r_ldst;
                        r_res.written_value <= r_rdata;
                        r_res.mem_address   <= r_laddr;
                        r_res.mem_data      <= r_rdata;
                    end
                    if (r_ins.opcode == OP_POP) begin
                        if (r_lok && r_ldst == SP) r_regs[SP] <= r_rdata + 32'd4;
                        else r_regs[SP] <= r_laddr + 32'd4;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

FILE: src/reg_stack_instruction_executor.sv
// reg_stack_instruction_executor: top level, ties controller and datapath
// depends on rse_pkg, rse_ctrl, rse_datapath
//
// usage notes
// - input channel: one instruction word per handshake (i_in_valid / o_in_ready)
// - output channel: one result word per instruction (o_out_valid / i_out_ready)
// - one instruction at a time: ready is high only while the sequencer is idle
// - nop, mov, add, sub, str raise valid in the state after decode; ldr passes
//   through an extra wait state for the registered stack memory read
// - push: decode plus a 16-step walk over the register list,
//   one step per register slot, bounded by the single stack memory write port
// - pop walks the same 16 steps and adds a wait state per listed register, since each load waits
//   for the registered memory read before sp advances
// - the next word can be accepted in the cycle after the result is taken
// - reset: all registers zero, sp at the memory top (4*STACK_WORDS);
//   stack memory content is undefined until written, no clearing pass
// - a stalled receiver holds the result word; no new word is taken until
//   the result has been delivered
module reg_stack_instruction_executor
    import rse_pkg::*;
#(
    parameter int unsigned STACK_WORDS = 1024,
    parameter int unsigned SP_INDEX    = 13
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    t_cmd    w_cmd;
    t_status w_status;

    // sequencer
    rse_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // register file, stack memory and result word
    rse_datapath #(
        .STACK_WORDS (STACK_WORDS),
        .SP_INDEX    (SP_INDEX)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_word  (i_in_word),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .o_out_word (o_out_word)
    );

    // never ready for a new word while a result is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("ready and result valid together");

    // an accepted word leads to a command to latch it
    a_load_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |-> (w_cmd.op == CMD_LOAD))
        else $error("accept without load");

    // after delivery the sequencer returns to idle
    a_idle_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready) |=> o_in_ready)
        else $error("not idle after delivery");

endmodule

FILE: dv/tb_reg_stack_instruction_executor.sv
// tb_reg_stack_instruction_executor: self-checking testbench for the register and stack executor
// predicts each result word from its own register file and stack image, depends on rse_pkg
`timescale 1ns / 100ps

module tb_reg_stack_instruction_executor;
    import rse_pkg::*;

    localparam int unsigned STACK_WORDS = 1024;
    localparam int unsigned AW          = $clog2(STACK_WORDS);
    localparam int unsigned SP_IDX      = 13;
    localparam int unsigned MEM_TOP     = 4 * STACK_WORDS;
    localparam int unsigned CYCLE_LIMIT = 400000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_word  in_word;
    logic      out_valid;
    logic      out_ready;
    t_out_word out_word;

    reg_stack_instruction_executor #(
        .STACK_WORDS(STACK_WORDS),
        .SP_INDEX   (SP_IDX)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_word  (in_word),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_word (out_word)
    );

    // predictor state: register file, stack image and which words were written
    logic [31:0] regs [16];
    logic [31:0] stack_img [STACK_WORDS];
    bit          stack_known [STACK_WORDS];

    t_in_word  pending_words [$];
    t_out_word expected_results [$];

    int  mismatches   = 0;
    int  results_seen = 0;
    int  words_sent   = 0;
    int  cycles       = 0;
    bit  idle_gaps;   // false during the stretch with no idling
    bit  hold_sender; // sender pause until everything is drained

    // accept flag captured at the rising edge for the driver
    logic in_ready_q;

    always begin
        clk = 1'b1; #4;
        clk = 1'b0; #4;
    end

    function automatic bit addr_ok(logic [31:0] a);
        return (a[1:0] == 2'b00) && (a < MEM_TOP);
    endfunction

    // compute the result word of one instruction and advance the predictor state
    function automatic t_out_word execute_instr(t_in_word w);
        t_out_word   r;
        logic [31:0] v;
        logic [31:0] a;
        logic [31:0] off;
        r   = '0;
        off = {{16{w.byte_offset[15]}}, w.byte_offset};
        case (w.opcode)
            OP_MOVREG, OP_MOVIMM, OP_ADDREG, OP_ADDIMM, OP_SUBREG, OP_SUBIMM: begin
                case (w.opcode)
                    OP_MOVREG: v = regs[w.src_reg];
                    OP_MOVIMM: v = w.immediate;
                    OP_ADDREG: v = regs[w.src_reg] + regs[w.src2_reg];
                    OP_ADDIMM: v = regs[w.src_reg] + w.immediate;
                    OP_SUBREG: v = regs[w.src_reg] - regs[w.src2_reg];
                    default:   v = regs[w.src_reg] - w.immediate;
                endcase
                regs[w.dst_reg] = v;
                r.reg_written = 1'b1; r.written_index = w.dst_reg; r.written_value = v;
            end
            OP_PUSH: begin
                for (int i = 15; i >= 0; i--) begin
                    if (w.register_list[i]) begin
                        regs[SP_IDX] = regs[SP_IDX] - 32'd4;
                        a = regs[SP_IDX];
                        v = regs[i];
                        if (addr_ok(a)) begin
                            stack_img[a[AW+1:2]] = v; stack_known[a[AW+1:2]] = 1'b1;
                            r.mem_written = 1'b1; r.mem_address = a; r.mem_data = v;
                        end else begin
                            r.address_fault = 1'b1;
                        end
                    end
                end
            end
            OP_POP: begin
                for (int i = 0; i < 16; i++) begin
                    if (w.register_list[i]) begin
                        a = regs[SP_IDX];
                        if (addr_ok(a)) begin
                            v = stack_img[a[AW+1:2]];
                            regs[i] = v;
                            r.reg_written = 1'b1; r.written_index = 4'(i);
                            r.written_value = v;
                            r.mem_address = a; r.mem_data = v;
                        end else begin
                            r.address_fault = 1'b1;
                        end
                        regs[SP_IDX] = regs[SP_IDX] + 32'd4;
                    end
                end
            end
            OP_STR: begin
                a = regs[w.src_reg] + off;
                v = regs[w.dst_reg];
                if (addr_ok(a)) begin
                    stack_img[a[AW+1:2]] = v; stack_known[a[AW+1:2]] = 1'b1;
                    r.mem_written = 1'b1; r.mem_address = a; r.mem_data = v;
                end else begin
                    r.address_fault = 1'b1;
                end
            end
            OP_LDR: begin
                a = regs[w.src_reg] + off;
                if (addr_ok(a)) begin
                    v = stack_img[a[AW+1:2]];
                    regs[w.dst_reg] = v;
                    r.reg_written = 1'b1; r.written_index = w.dst_reg; r.written_value = v;
                    r.mem_address = a; r.mem_data = v;
                end else begin
                    r.address_fault = 1'b1;
                end
            end
            default: ;
        endcase
        r.stack_pointer = regs[SP_IDX];
        return r;
    endfunction

    // true if the instruction would read a stack word that was never written
    function automatic bit reads_unknown(t_in_word w);
        logic [31:0] sp;
        logic [31:0] a;
        logic [31:0] off;
        off = {{16{w.byte_offset[15]}}, w.byte_offset};
        if (w.opcode == OP_LDR) begin
            a = regs[w.src_reg] + off;
            return addr_ok(a) && !stack_known[a[AW+1:2]];
        end
        if (w.opcode == OP_POP) begin
            sp = regs[SP_IDX];
            for (int i = 0; i < 16; i++) begin
                if (w.register_list[i]) begin
                    if (addr_ok(sp)) begin
                        if (!stack_known[sp[AW+1:2]]) return 1'b1;
                        // sp in the list jumps to the loaded word
                        if (i == SP_IDX) sp = stack_img[sp[AW+1:2]];
                    end
                    sp = sp + 32'd4;
                end
            end
        end
        return 1'b0;
    endfunction

    // queue an instruction (as a nop if it reads an unwritten stack word), expectation computed now in program order
    task automatic issue(t_in_word w);
        if (reads_unknown(w)) begin
            w.opcode = OP_NOP;
        end
        expected_results.push_back(execute_instr(w));
        pending_words.push_back(w);
    endtask

    function automatic t_in_word rand_word();
        t_in_word w;
        w.opcode        = 4'($urandom_range(0, 15));
        w.dst_reg       = 4'($urandom_range(0, 15));
        w.src_reg       = 4'($urandom_range(0, 15));
        w.src2_reg      = 4'($urandom_range(0, 15));
        w.immediate     = $urandom;
        w.byte_offset   = 16'($urandom);
        w.register_list = 16'($urandom);
        return w;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp);
        mismatches++;
        $display("mismatch on result %0d: %s got %h expected %h", results_seen, what, got, exp);
    endtask

    // driver: valid held until accepted, changes only at falling edge
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_word  <= '0;
        end else if (!(in_valid && in_ready_q)) begin
            if (!in_valid && pending_words.size() > 0 && !hold_sender
                && !(idle_gaps && $urandom_range(0, 99) < 32)) begin
                in_word  <= pending_words.pop_front();
                in_valid <= 1'b1;
            end
        end else begin
            // word was taken at the last rising edge
            if (pending_words.size() > 0 && !hold_sender
                && !(idle_gaps && $urandom_range(0, 99) < 32)) begin
                in_word  <= pending_words.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
        out_ready <= rst_n ? !(idle_gaps && $urandom_range(0, 99) < 32) : 1'b0;
    end

    always @(posedge clk) begin
        in_ready_q <= in_valid && in_ready;
        if (in_valid && in_ready) words_sent++;
        cycles++;
    end

    // monitor: compare each delivered word with the oldest expectation
    always @(posedge clk) begin
        t_out_word e;
        if (rst_n && out_valid && out_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected word sp", out_word.stack_pointer, 32'd0);
            end else begin
                e = expected_results.pop_front();
                if (out_word.reg_written !== e.reg_written)
                    report_mismatch("reg_written", out_word.reg_written, e.reg_written);
                if (out_word.written_index !== e.written_index)
                    report_mismatch("written_index", out_word.written_index, e.written_index);
                if (out_word.written_value !== e.written_value)
                    report_mismatch("written_value", out_word.written_value, e.written_value);
                if (out_word.stack_pointer !== e.stack_pointer)
                    report_mismatch("stack_pointer", out_word.stack_pointer, e.stack_pointer);
                if (out_word.mem_written !== e.mem_written)
                    report_mismatch("mem_written", out_word.mem_written, e.mem_written);
                if (out_word.mem_address !== e.mem_address)
                    report_mismatch("mem_address", out_word.mem_address, e.mem_address);
                if (out_word.mem_data !== e.mem_data)
                    report_mismatch("mem_data", out_word.mem_data, e.mem_data);
                if (out_word.address_fault !== e.address_fault)
                    report_mismatch("address_fault", out_word.address_fault, e.address_fault);
            end
            results_seen++;
        end
    end

    // watchdog
    always @(posedge clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, expected_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        t_in_word w;
        int       n;
        rst_n       = 1'b0;
        idle_gaps   = 1'b1;
        hold_sender = 1'b0;
        for (int i = 0; i < 16; i++) regs[i] = '0;
        regs[SP_IDX] = MEM_TOP;
        for (int i = 0; i < STACK_WORDS; i++) stack_known[i] = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: every opcode, field extremes, fault and sp corner cases
        w = '0;
        w.opcode = OP_MOVIMM; w.dst_reg = 4'd0; w.immediate = 32'hFFFF_FFFF; issue(w);
        w.dst_reg = 4'd15; w.immediate = 32'h8000_0001; issue(w);
        w.opcode = OP_ADDIMM; w.dst_reg = 4'd1; w.src_reg = 4'd0; w.immediate = 32'd1;
        issue(w); // wraps to zero
        w.opcode = OP_SUBIMM; w.dst_reg = 4'd2; w.src_reg = 4'd1; w.immediate = 32'd1;
        issue(w); // wraps below zero
        w.opcode = OP_ADDREG; w.dst_reg = 4'd3; w.src_reg = 4'd0; w.src2_reg = 4'd15; issue(w);
        w.opcode = OP_SUBREG; w.dst_reg = 4'd4; w.src_reg = 4'd15; w.src2_reg = 4'd0; issue(w);
        w.opcode = OP_MOVREG; w.dst_reg = 4'd5; w.src_reg = 4'd13; issue(w);
        w = '0; w.opcode = OP_NOP; w.immediate = 32'hFFFF_FFFF; w.register_list = 16'hFFFF;
        issue(w);
        w.opcode = 4'd15; issue(w); // unused opcode acts as nop
        w = '0; w.opcode = OP_PUSH; w.register_list = 16'h0000; issue(w); // empty list
        w.register_list = 16'hFFFF; issue(w); // full list, sp stored pre-decremented
        w.opcode = OP_POP; w.register_list = 16'hDFFF; issue(w); // all but sp
        w.register_list = 16'h2000; issue(w); // sp only, takes the loaded word
        w.opcode = OP_MOVIMM; w.dst_reg = 4'd13; w.immediate = MEM_TOP; issue(w);
        w = '0; w.opcode = OP_POP; w.register_list = 16'h0001; issue(w); // faults at top
        w = '0; w.opcode = OP_STR; w.dst_reg = 4'd15; w.src_reg = 4'd13;
        w.byte_offset = -16'sd4; issue(w);
        w.byte_offset = -16'sd32768; issue(w); // below zero, wraps, faults
        w.byte_offset = 16'sd32767; issue(w); // unaligned and beyond
        w.opcode = OP_LDR; w.dst_reg = 4'd6; w.byte_offset = -16'sd4; issue(w);
        w.byte_offset = -16'sd2; issue(w); // unaligned
        w = '0; w.opcode = OP_MOVIMM; w.dst_reg = 4'd13; w.immediate = 32'd8; issue(w);
        w = '0; w.opcode = OP_PUSH; w.register_list = 16'h8007; issue(w); // runs off bottom
        w = '0; w.opcode = OP_MOVIMM; w.dst_reg = 4'd13; w.immediate = MEM_TOP - 64; issue(w);

        // random: mostly sane sp and in-range ldr/str, some raw noise
        for (int k = 0; k < 500; k++) begin
            w = rand_word();
            n = $urandom_range(0, 99);
            if (n < 8) begin
                // put sp back into the memory, rarely at an odd or far value
                w.opcode = OP_MOVIMM; w.dst_reg = 4'(SP_IDX);
                w.immediate = ($urandom_range(0, 9) == 0) ? $urandom
                            : 4 * $urandom_range(16, STACK_WORDS);
            end else if (n < 20) begin
                w.opcode = OP_PUSH;
                if ($urandom_range(0, 3) != 0) w.register_list &= 16'($urandom);
            end else if (n < 30) begin
                w.opcode = OP_POP;
                if ($urandom_range(0, 3) != 0) w.register_list &= 16'($urandom);
            end else if (n < 55) begin
                w.opcode = ($urandom_range(0, 1) != 0) ? OP_STR : OP_LDR;
                if ($urandom_range(0, 4) != 0) begin
                    w.src_reg = 4'(SP_IDX);
                    w.byte_offset = 16'(4 * $signed($urandom_range(0, 32)) - 64);
                end
            end else if (n < 62) begin
                w.opcode = OP_PUSH; // push then pop the same list below
                issue(w);
                w.opcode = OP_POP;
            end
            if (k == 250) begin
                issue(w);
                wait (pending_words.size() == 0);
                hold_sender = 1'b1;
                wait (expected_results.size() == 0);
                @(negedge clk);
                hold_sender = 1'b0;
            end else begin
                issue(w);
            end
            if (k == 100) begin
                wait (pending_words.size() == 0);
                idle_gaps = 1'b0;
            end
            if (k == 200) begin
                wait (pending_words.size() == 0);
                idle_gaps = 1'b1;
            end
        end

        wait (pending_words.size() == 0 && expected_results.size() == 0);
        repeat (40) @(posedge clk);
        $display("ran %0d instructions, %0d result words checked, %0d mismatches",
                 words_sent, results_seen, mismatches);
        $display("covered all opcodes, push/pop with sp listed, faulting and wrapping accesses");
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
